// ===== rtl/core/c_subset_lexer_top_assert.svh =====
// Assertion helpers used by the lexer control block (clex_ctrl).
`ifndef C_SUBSET_LEXER_TOP_ASSERT_SVH
`define C_SUBSET_LEXER_TOP_ASSERT_SVH

// Plain property check, disabled during reset.
`define CLEX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication check: when ante holds, cons holds in the same cycle.
`define CLEX_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Implication check: when ante holds, cons holds in the next cycle.
`define CLEX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/clex_pkg.sv =====
package clex_pkg;

   localparam int MAX_TEXT_DEF = 32;
   localparam int NUM_KW       = 13;

   localparam logic [5:0] CLS_IDENT    = 6'd0;
   localparam logic [5:0] CLS_INT      = 6'd1;
   localparam logic [5:0] CLS_CHAR     = 6'd2;
   localparam logic [5:0] CLS_STRING   = 6'd3;
   localparam logic [5:0] CLS_KW_BASE  = 6'd4;
   localparam logic [5:0] CLS_SYM_BASE = 6'd17;
   localparam logic [5:0] CLS_LSS      = 6'd29;
   localparam logic [5:0] CLS_LEQ      = 6'd30;
   localparam logic [5:0] CLS_GRE      = 6'd31;
   localparam logic [5:0] CLS_GEQ      = 6'd32;
   localparam logic [5:0] CLS_EQL      = 6'd33;
   localparam logic [5:0] CLS_NEQ      = 6'd34;
   localparam logic [5:0] CLS_ASSIGN   = 6'd35;
   localparam logic [5:0] CLS_UNKNOWN  = 6'd36;

   // Keywords padded with spaces to six characters, first char in the top byte.
   localparam logic [47:0] KW_TEXT [NUM_KW] = '{
      "const ", "int   ", "char  ", "void  ", "main  ", "if    ", "else  ",
      "do    ", "while ", "for   ", "scanf ", "printf", "return"
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
   };

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_beat_type;

   typedef struct packed {
      logic [5:0] token_class;
      logic [7:0] text_byte;
      logic       text_valid;
      logic       last_of_token;
      logic       truncated;
   } rsp_beat_type;

   typedef struct packed {
      logic shift;
      logic wr;
   } cell_ctl_type;

   function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
      logic [47:0] w;
      w = KW_TEXT[k];
      return w[8*(5 - int'(pos)) +: 8];
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   // One-character symbol class, or unknown.
   function automatic logic [5:0] sym_class(input logic [7:0] b);
      logic [5:0] c;
      case (b)
         8'h2B:   c = CLS_SYM_BASE;
         8'h2D:   c = CLS_SYM_BASE + 6'd1;
         8'h2A:   c = CLS_SYM_BASE + 6'd2;
         8'h2F:   c = CLS_SYM_BASE + 6'd3;
         8'h3B:   c = CLS_SYM_BASE + 6'd4;
         8'h2C:   c = CLS_SYM_BASE + 6'd5;
         8'h28:   c = CLS_SYM_BASE + 6'd6;
         8'h29:   c = CLS_SYM_BASE + 6'd7;
         8'h5B:   c = CLS_SYM_BASE + 6'd8;
         8'h5D:   c = CLS_SYM_BASE + 6'd9;
         8'h7B:   c = CLS_SYM_BASE + 6'd10;
         8'h7D:   c = CLS_SYM_BASE + 6'd11;
         default: c = CLS_UNKNOWN;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/clex_cell.sv =====
module clex_cell #(
   parameter int IDX = 0,
   parameter int LW  = 6
) (
   input  logic                  clock,
   input  clex_pkg::cell_ctl_type ctl,
   input  logic [LW-1:0]         wr_pos,
   input  logic [7:0]            wr_data,
   input  logic [7:0]            next_byte,
   output logic [7:0]            byte_q
);
   import clex_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      if (ctl.shift) begin
         data_in = next_byte;
      end else if (ctl.wr && (wr_pos == LW'(IDX))) begin
         data_in = wr_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign byte_q = data_ff;

endmodule

// ===== rtl/core/clex_ctrl.sv =====
`include "c_subset_lexer_top_assert.svh"

module clex_ctrl #(
   parameter int MAX_TEXT = clex_pkg::MAX_TEXT_DEF,
   parameter int LW       = $clog2(MAX_TEXT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  clex_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output clex_pkg::rsp_beat_type rsp_data,
   input  logic [7:0]             head_byte,
   output clex_pkg::cell_ctl_type cell_ctl,
   output logic [LW-1:0]          wr_pos,
   output logic [7:0]             wr_data
);
   import clex_pkg::*;

   localparam logic [3:0] MODE_IDLE      = 4'd0;
   localparam logic [3:0] MODE_IDENT     = 4'd1;
   localparam logic [3:0] MODE_NUMBER    = 4'd2;
   localparam logic [3:0] MODE_STRING    = 4'd3;
   localparam logic [3:0] MODE_CHAR_OPEN = 4'd4;
   localparam logic [3:0] MODE_CHAR_GOT  = 4'd5;
   localparam logic [3:0] MODE_GT        = 4'd6;
   localparam logic [3:0] MODE_LT        = 4'd7;
   localparam logic [3:0] MODE_EQ        = 4'd8;
   localparam logic [3:0] MODE_BANG      = 4'd9;

   logic [3:0]        mode_ff, mode_in;
   logic [LW-1:0]     len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic              drain_ff, drain_in;
   logic              replay_ff, replay_in;
   logic [7:0]        held_ff, held_in;
   logic [5:0]        cls_ff, cls_in;
   logic [NUM_KW-1:0] match_ff, match_in, match_upd;

   logic       go;
   logic [7:0] b;
   logic       eoi;
   logic       act_app, act_emit, act_rep;
   logic [3:0] act_mode;
   logic [5:0] act_cls;
   logic [5:0] word_cls;

   assign req_ready = !drain_ff && !replay_ff;
   // the held byte waits until the row has fully drained
   assign go        = (replay_ff && !drain_ff) || (req_valid && req_ready);
   assign b         = replay_ff ? held_ff : req_data.in_byte;
   assign eoi       = !replay_ff && req_data.end_of_input;

   // Keyword match vector is built one byte at a time as the identifier grows.
   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         match_upd[k] = ((len_ff == '0) || match_ff[k]) && (len_ff < LW'(6)) &&
                        (kw_char(k, len_ff[2:0]) == b);
      end
   end

   always_comb begin
      word_cls = CLS_IDENT;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (!ovf_ff && match_ff[k] && (len_ff == LW'(KW_LEN[k]))) begin
            word_cls = CLS_KW_BASE + 6'(k);
         end
      end
   end

   // Per-byte decode. A byte that ends an identifier, number or lone compare is replayed from idle after the drain.
   always_comb begin
      act_app  = 1'b0;
      act_emit = 1'b0;
      act_rep  = 1'b0;
      act_mode = MODE_IDLE;
      act_cls  = CLS_UNKNOWN;
      if (eoi) begin
         act_emit = 1'b1;
         case (mode_ff)
            MODE_IDENT:     act_cls = word_cls;
            MODE_NUMBER:    act_cls = CLS_INT;
            MODE_STRING:    act_cls = CLS_STRING;
            MODE_CHAR_OPEN: act_cls = CLS_CHAR;
            MODE_CHAR_GOT:  act_cls = CLS_CHAR;
            MODE_GT:        act_cls = CLS_GRE;
            MODE_LT:        act_cls = CLS_LSS;
            MODE_EQ:        act_cls = CLS_ASSIGN;
            MODE_BANG:      act_cls = CLS_UNKNOWN;
            default:        act_emit = 1'b0;
         endcase
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_letter(b) || is_digit(b)) begin
                  act_app  = 1'b1;
                  act_mode = MODE_IDENT;
               end else begin
                  act_emit = 1'b1;
                  act_rep  = 1'b1;
                  act_cls  = word_cls;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(b)) begin
                  act_app  = 1'b1;
                  act_mode = MODE_NUMBER;
               end else begin
                  act_emit = 1'b1;
                  act_rep  = 1'b1;
                  act_cls  = CLS_INT;
               end
            end
            MODE_STRING: begin
               if (b == 8'h22) begin
                  act_emit = 1'b1;
                  act_cls  = CLS_STRING;
               end else begin
                  act_app  = 1'b1;
                  act_mode = MODE_STRING;
               end
            end
            MODE_CHAR_OPEN: begin
               act_app  = 1'b1;
               act_mode = MODE_CHAR_GOT;
            end
            MODE_CHAR_GOT: begin
               act_emit = 1'b1;
               act_cls  = CLS_CHAR;
            end
            MODE_GT, MODE_LT, MODE_EQ, MODE_BANG: begin
               act_emit = 1'b1;
               if (b == 8'h3D) begin
                  act_app = 1'b1;
                  case (mode_ff)
                     MODE_GT: act_cls = CLS_GEQ;
                     MODE_LT: act_cls = CLS_LEQ;
                     MODE_EQ: act_cls = CLS_EQL;
                     default: act_cls = CLS_NEQ;
                  endcase
               end else begin
                  act_rep = 1'b1;
                  case (mode_ff)
                     MODE_GT: act_cls = CLS_GRE;
                     MODE_LT: act_cls = CLS_LSS;
                     MODE_EQ: act_cls = CLS_ASSIGN;
                     default: act_cls = CLS_UNKNOWN;
                  endcase
               end
            end
            default: begin
               if (is_space(b)) begin
                  act_mode = MODE_IDLE;
               end else if (is_letter(b)) begin
                  act_app  = 1'b1;
                  act_mode = MODE_IDENT;
               end else if (is_digit(b)) begin
                  act_app  = 1'b1;
                  act_mode = MODE_NUMBER;
               end else if (b == 8'h22) begin
                  act_mode = MODE_STRING;
               end else if (b == 8'h27) begin
                  act_mode = MODE_CHAR_OPEN;
               end else if (b == 8'h3E) begin
                  act_app  = 1'b1;
                  act_mode = MODE_GT;
               end else if (b == 8'h3C) begin
                  act_app  = 1'b1;
                  act_mode = MODE_LT;
               end else if (b == 8'h3D) begin
                  act_app  = 1'b1;
                  act_mode = MODE_EQ;
               end else if (b == 8'h21) begin
                  act_app  = 1'b1;
                  act_mode = MODE_BANG;
               end else begin
                  act_app  = 1'b1;
                  act_emit = 1'b1;
                  act_cls  = sym_class(b);
               end
            end
         endcase
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      drain_in  = drain_ff;
      replay_in = replay_ff;
      held_in   = held_ff;
      cls_in    = cls_ff;
      match_in  = match_ff;
      cell_ctl  = '{shift: 1'b0, wr: 1'b0};
      if (go) begin
         mode_in = act_mode;
         if (act_app) begin
            if (len_ff < LW'(MAX_TEXT)) begin
               cell_ctl.wr = 1'b1;
               len_in      = len_ff + LW'(1);
               match_in    = match_upd;
            end else begin
               ovf_in = 1'b1;
            end
         end
         if (act_emit) begin
            drain_in  = 1'b1;
            cls_in    = act_cls;
            replay_in = act_rep;
            held_in   = b;
         end else begin
            replay_in = 1'b0;
         end
      end else if (drain_ff && rsp_ready) begin
         cell_ctl.shift = 1'b1;
         if (len_ff <= LW'(1)) begin
            len_in   = '0;
            ovf_in   = 1'b0;
            drain_in = 1'b0;
         end else begin
            len_in = len_ff - LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         drain_ff  <= 1'b0;
         replay_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         drain_ff  <= drain_in;
         replay_ff <= replay_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      cls_ff   <= cls_in;
      match_ff <= match_in;
   end

   assign wr_pos  = len_ff;
   assign wr_data = b;

   assign rsp_valid              = drain_ff;
   assign rsp_data.token_class   = cls_ff;
   assign rsp_data.text_valid    = (len_ff != '0);
   assign rsp_data.text_byte     = (len_ff != '0) ? head_byte : 8'h00;
   assign rsp_data.last_of_token = (len_ff <= LW'(1));
   assign rsp_data.truncated     = ovf_ff;

   `CLEX_ASSERT(a_len_bound, len_ff <= LW'(MAX_TEXT), "text length past buffer size")
   `CLEX_ASSERT_IMPL(a_ovf_full, ovf_ff && !drain_ff, len_ff == LW'(MAX_TEXT),
                     "overflow with buffer not full")
   `CLEX_ASSERT_IMPL(a_replay_idle, replay_ff, mode_ff == MODE_IDLE, "replay outside idle")
   `CLEX_ASSERT_IMPL(a_idle_empty, !drain_ff && (mode_ff == MODE_IDLE), len_ff == '0,
                     "idle with text left in buffer")
   `CLEX_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_data.last_of_token, !drain_ff,
                     "drain continues past last beat")

endmodule

// ===== rtl/core/c_subset_lexer_top.sv =====
// Streaming tokenizer for a small C subset.
// req channel: one source byte per beat (in_byte), or an end_of_input beat that
// flushes a pending token; the byte of an end_of_input beat is ignored.
// rsp channel: one beat per token text byte, every beat carrying token_class,
// last_of_token on the final beat and truncated when the text passed MAX_TEXT
// bytes. A token with empty text (e.g. "") gives one beat with text_valid low.
// Text is held in a row of MAX_TEXT byte cells; draining shifts the row one
// cell toward the head per rsp beat.
// Flow: a byte that continues or starts a token is consumed as it is accepted. A
// token of N text bytes (one beat if empty) then drains from the next cycle on,
// one rsp beat per accepted handshake. A byte that ends an identifier, number or
// lone compare is replayed from idle once the drain is done.
// req_ready is low while the row drains or a byte is replayed; a stalled rsp
// side holds the current beat and the row in place.
// Reset: synchronous, active high; clears the lexer to idle with an empty
// buffer. The cell contents are not cleared and need not be.
module c_subset_lexer_top #(
   parameter int MAX_TEXT = clex_pkg::MAX_TEXT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  clex_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output clex_pkg::rsp_beat_type rsp_data
);
   import clex_pkg::*;

   localparam int LW = $clog2(MAX_TEXT + 1);

   cell_ctl_type  cell_ctl;
   logic [LW-1:0] wr_pos;
   logic [7:0]    wr_data;
   logic [7:0]    cell_q [MAX_TEXT];

   clex_ctrl #(
      .MAX_TEXT(MAX_TEXT),
      .LW      (LW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .head_byte(cell_q[0]),
      .cell_ctl (cell_ctl),
      .wr_pos   (wr_pos),
      .wr_data  (wr_data)
   );

   for (genvar i = 0; i < MAX_TEXT; i++) begin : g_cell
      logic [7:0] next_byte;
      if (i == MAX_TEXT - 1) begin : g_tail
         assign next_byte = 8'h00;
      end else begin : g_link
         assign next_byte = cell_q[i+1];
      end
      clex_cell #(
         .IDX(i),
         .LW (LW)
      ) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .wr_pos   (wr_pos),
         .wr_data  (wr_data),
         .next_byte(next_byte),
         .byte_q   (cell_q[i])
      );
   end

endmodule

// ===== tb/c_subset_lexer_checker.sv =====
`timescale 1ns / 1ps

module c_subset_lexer_checker
   import clex_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_beat_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_beat_type rsp_data,
   output int           fail_count,
   output int           beats_owed,
   output int           tokens_seen
);

   localparam int TEXT_DEPTH = MAX_TEXT_DEF;

   typedef enum logic [3:0] {
      LX_IDLE, LX_IDENT, LX_NUMBER, LX_STRING, LX_CHAR_OPEN, LX_CHAR_GOT,
      LX_GT, LX_LT, LX_EQ, LX_BANG
   } lex_state_e;

   lex_state_e   scan_state = LX_IDLE;
   logic [7:0]   tok_text [TEXT_DEPTH];
   int unsigned  tok_len = 0;
   logic         tok_cut = 1'b0;
   rsp_beat_type token_beats_q [$];

   string kw_words [NUM_KW] = '{
      "const", "int", "char", "void", "main", "if", "else",
      "do", "while", "for", "scanf", "printf", "return"
   };
   string sym_chars = "+-*/;,()[]{}";

   function automatic logic blank_byte(input logic [7:0] b);
      return b == " " || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic word_byte(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic digit_byte(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic [5:0] symbol_class(input logic [7:0] b);
      for (int i = 0; i < sym_chars.len(); i++)
         if (b == sym_chars[i]) return CLS_SYM_BASE + 6'(i);
      return CLS_UNKNOWN;
   endfunction

   // overflowed words never match a keyword
   function automatic logic [5:0] word_class();
      logic hit;
      if (tok_cut) return CLS_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
         if (tok_len == kw_words[k].len()) begin
            hit = 1'b1;
            for (int i = 0; i < tok_len; i++)
               if (tok_text[i] != kw_words[k][i]) hit = 1'b0;
            if (hit) return CLS_KW_BASE + 6'(k);
         end
      end
      return CLS_IDENT;
   endfunction

   task automatic keep_byte(input logic [7:0] b);
      if (tok_len < TEXT_DEPTH) begin
         tok_text[tok_len] = b;
         tok_len++;
      end else begin
         tok_cut = 1'b1;
      end
   endtask

   task automatic close_token(input logic [5:0] cls);
      rsp_beat_type beat;
      beat.token_class = cls;
      beat.truncated   = tok_cut;
      if (tok_len == 0) begin
         beat.text_byte     = 8'h00;
         beat.text_valid    = 1'b0;
         beat.last_of_token = 1'b1;
         token_beats_q.push_back(beat);
      end else begin
         for (int i = 0; i < tok_len; i++) begin
            beat.text_byte     = tok_text[i];
            beat.text_valid    = 1'b1;
            beat.last_of_token = (i + 1 == tok_len);
            token_beats_q.push_back(beat);
         end
      end
      tok_len    = 0;
      tok_cut    = 1'b0;
      scan_state = LX_IDLE;
   endtask

   task automatic open_token(input logic [7:0] b);
      scan_state = LX_IDLE;
      if (blank_byte(b)) begin
      end else if (word_byte(b)) begin
         keep_byte(b);
         scan_state = LX_IDENT;
      end else if (digit_byte(b)) begin
         keep_byte(b);
         scan_state = LX_NUMBER;
      end else if (b == "\"") begin
         scan_state = LX_STRING;
      end else if (b == "'") begin
         scan_state = LX_CHAR_OPEN;
      end else if (b == ">") begin
         keep_byte(b);
         scan_state = LX_GT;
      end else if (b == "<") begin
         keep_byte(b);
         scan_state = LX_LT;
      end else if (b == "=") begin
         keep_byte(b);
         scan_state = LX_EQ;
      end else if (b == "!") begin
         keep_byte(b);
         scan_state = LX_BANG;
      end else begin
         keep_byte(b);
         close_token(symbol_class(b));
      end
   endtask

   // second byte of a possible pair; anything but '=' restarts the scan
   task automatic close_pair(input logic [7:0] b, input logic [5:0] pair_cls,
                             input logic [5:0] single_cls);
      if (b == "=") begin
         keep_byte(b);
         close_token(pair_cls);
      end else begin
         close_token(single_cls);
         open_token(b);
      end
   endtask

   task automatic lex_beat(input req_beat_type beat);
      logic [7:0] b;
      b = beat.in_byte;
      if (beat.end_of_input) begin
         case (scan_state)
            LX_IDENT:                  close_token(word_class());
            LX_NUMBER:                 close_token(CLS_INT);
            LX_STRING:                 close_token(CLS_STRING);
            LX_CHAR_OPEN, LX_CHAR_GOT: close_token(CLS_CHAR);
            LX_GT:                     close_token(CLS_GRE);
            LX_LT:                     close_token(CLS_LSS);
            LX_EQ:                     close_token(CLS_ASSIGN);
            LX_BANG:                   close_token(CLS_UNKNOWN);
            default: begin
               tok_len    = 0;
               tok_cut    = 1'b0;
               scan_state = LX_IDLE;
            end
         endcase
      end else begin
         case (scan_state)
            LX_IDENT: begin
               if (word_byte(b) || digit_byte(b)) begin
                  keep_byte(b);
               end else begin
                  close_token(word_class());
                  open_token(b);
               end
            end
            LX_NUMBER: begin
               if (digit_byte(b)) begin
                  keep_byte(b);
               end else begin
                  close_token(CLS_INT);
                  open_token(b);
               end
            end
            LX_STRING: begin
               if (b == "\"") close_token(CLS_STRING);
               else keep_byte(b);
            end
            LX_CHAR_OPEN: begin
               keep_byte(b);
               scan_state = LX_CHAR_GOT;
            end
            LX_CHAR_GOT: close_token(CLS_CHAR);
            LX_GT:       close_pair(b, CLS_GEQ, CLS_GRE);
            LX_LT:       close_pair(b, CLS_LEQ, CLS_LSS);
            LX_EQ:       close_pair(b, CLS_EQL, CLS_ASSIGN);
            LX_BANG:     close_pair(b, CLS_NEQ, CLS_UNKNOWN);
            default: begin
               tok_len = 0;
               tok_cut = 1'b0;
               open_token(b);
            end
         endcase
      end
   endtask

   task automatic check_beat(input rsp_beat_type got);
      rsp_beat_type want;
      if (token_beats_q.size() == 0) begin
         $display("%0t ns: rsp beat with nothing expected: class %0d byte %h valid %b last %b cut %b",
                  $time, got.token_class, got.text_byte, got.text_valid,
                  got.last_of_token, got.truncated);
         fail_count++;
      end else begin
         want = token_beats_q.pop_front();
         if (got.token_class !== want.token_class || got.text_byte !== want.text_byte ||
             got.text_valid !== want.text_valid || got.last_of_token !== want.last_of_token ||
             got.truncated !== want.truncated) begin
            $display({"%0t ns: rsp beat mismatch, expected class %0d byte %h valid %b last %b",
                      " cut %b, got class %0d byte %h valid %b last %b cut %b"},
                     $time, want.token_class, want.text_byte, want.text_valid,
                     want.last_of_token, want.truncated, got.token_class, got.text_byte,
                     got.text_valid, got.last_of_token, got.truncated);
            fail_count++;
         end
      end
      if (got.last_of_token) tokens_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_state = LX_IDLE;
         tok_len    = 0;
         tok_cut    = 1'b0;
         token_beats_q.delete();
      end else begin
         // a beat that ends a token can only drain on a later edge
         if (req_valid && req_ready) lex_beat(req_data);
         if (rsp_valid && rsp_ready) check_beat(rsp_data);
      end
      beats_owed <= token_beats_q.size();
   end

endmodule

// ===== tb/tb_c_subset_lexer_top.sv =====
`timescale 1ns / 1ps

module tb_c_subset_lexer_top;
   import clex_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int SOURCE_BEATS = 210;
   localparam int QUIET_AFTER  = 175;
   localparam int PAUSE_AT     = 100;
   localparam int DRAIN_CYCLES = 80;
   localparam int LIMIT_CYCLES = 400_000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         rsp_ready = 1'b0;
   req_beat_type req_data  = '0;
   logic         req_ready;
   logic         rsp_valid;
   rsp_beat_type rsp_data;

   int   fail_count;
   int   beats_owed;
   int   tokens_seen;
   int   src_count   = 0;
   int   send_odds   = 6;
   int   stall_odds  = 6;
   logic quiet_tail  = 1'b0;
   logic paused_mid  = 1'b0;

   string kw_words [NUM_KW] = '{
      "const", "int", "char", "void", "main", "if", "else",
      "do", "while", "for", "scanf", "printf", "return"
   };
   // letters and '_' first, digits last so a word can start from the head only
   string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string op_chars   = "+-*/;,()[]{}<>=!";
   string pair_ops [4] = '{"<=", ">=", "==", "!="};

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   c_subset_lexer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   c_subset_lexer_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .beats_owed  (beats_owed),
      .tokens_seen (tokens_seen)
   );

   // valid stays high after a beat so the next one can follow back to back
   task automatic send_beat(input logic [7:0] b, input logic eoi);
      int gap;
      if (!quiet_tail && send_odds != 0 && $urandom_range(0, send_odds) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, end_of_input: eoi};
      do @(posedge clock); while (!req_ready);
      if (!eoi && b != " " && !(b >= 8'h09 && b <= 8'h0D)) src_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
   endtask

   function automatic int text_len(input int lo, input int hi);
      // now and then run past the text buffer, or stop right at its edge
      case ($urandom_range(0, 11))
         0:       return $urandom_range(MAX_TEXT_DEF + 1, MAX_TEXT_DEF + 8);
         1:       return MAX_TEXT_DEF;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   task automatic send_random_token();
      int         n;
      logic [7:0] b;
      case ($urandom_range(0, 19))
         0, 1, 2, 3: send_text(kw_words[$urandom_range(0, NUM_KW - 1)]);
         4, 5, 6: begin
            n = text_len(1, 8);
            send_beat(word_chars[$urandom_range(0, 52)], 1'b0);
            repeat (n - 1) send_beat(word_chars[$urandom_range(0, 62)], 1'b0);
         end
         7, 8: begin
            n = text_len(1, 6);
            repeat (n) send_beat(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
         end
         9, 10: begin
            n = text_len(0, 6);
            send_beat("\"", 1'b0);
            repeat (n) begin
               do b = 8'($urandom_range(0, 255)); while (b == "\"");
               send_beat(b, 1'b0);
            end
            if ($urandom_range(0, 7) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
            else send_beat("\"", 1'b0);
         end
         11: begin
            send_beat("'", 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b0);
            send_beat(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : "'", 1'b0);
         end
         12, 13, 14: send_beat(op_chars[$urandom_range(0, op_chars.len() - 1)], 1'b0);
         15, 16:     send_text(pair_ops[$urandom_range(0, 3)]);
         17, 18:     send_beat(8'($urandom_range(0, 255)), 1'b0);
         default:    send_beat(8'($urandom_range(0, 255)), 1'b1);
      endcase
      if ($urandom_range(0, 1) == 0) begin
         n = $urandom_range(0, 6);
         send_beat((n > 4) ? " " : 8'h09 + 8'(n), 1'b0);
      end
   endtask

   initial begin
      forever begin
         if (!quiet_tail && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // pairs and lone compares, char constant on 0xFF, empty string,
      // lone bang then unknown byte, flush in idle, flush after open quote
      send_text("while(a!=9)<=>'");
      send_beat(8'hFF, 1'b0);
      send_text("'\"\"!@");
      send_beat(8'h5A, 1'b1);
      send_beat(8'hA5, 1'b1);
      send_text("'");
      send_beat(8'h00, 1'b1);
      wait_drained();

      while (src_count < SOURCE_BEATS) begin
         if (src_count >= QUIET_AFTER) begin
            quiet_tail = 1'b1;
         end else if (src_count >= PAUSE_AT && !paused_mid) begin
            paused_mid = 1'b1;
            wait_drained();
         end else if ($urandom_range(0, 7) == 0) begin
            send_odds  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
         end
         send_random_token();
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d source bytes and %0d tokens,", src_count, tokens_seen);
      $display("keywords, long and empty text, char constants and flushes included");
      if (beats_owed != 0) $display("%0d expected rsp beats never came", beats_owed);
      if (fail_count == 0 && beats_owed == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("timeout waiting on the lexer");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
